// ===== rtl/core/tst_pkg.sv =====
// Types, codes and helpers shared by the timing statistics table.
package tst_pkg;

	// Default number of table entries.
	localparam int ENTRIES_DEFAULT = 16;

	// Operation codes carried on the input tuser.
	typedef enum logic [2:0] {
		OP_REGISTER  = 3'd0,
		OP_RECORD    = 3'd1,
		OP_RESET_ONE = 3'd2,
		OP_RESET_ALL = 3'd3,
		OP_QUERY     = 3'd4
	} op_t;

	// Status codes carried on the output tuser.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NULL_KEY  = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_CLEAR,
		S_EMIT
	} state_t;

	// Statistics of one entry, as held in the statistics memory.
	typedef struct packed {
		logic [31:0] calls;
		logic [63:0] total_time;
		logic [31:0] min_time;
		logic [31:0] max_time;
		logic [31:0] last_time;
	} stats_t;

	// One result before the fill count is attached.
	typedef struct packed {
		status_t     status;
		logic [3:0]  result_index;
		logic [31:0] entry_key;
		stats_t      stats;
	} rslt_t;

	// Statistics of an entry that has never been timed.
	function automatic stats_t cleared_stats();
		stats_t s;
		s.calls      = '0;
		s.total_time = '0;
		s.min_time   = '1;
		s.max_time   = '0;
		s.last_time  = '0;
		return s;
	endfunction

endpackage

// ===== rtl/core/tst_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module tst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/timing_statistics_table.sv =====
// Top level of the timing statistics table: sequencer, entry count and result register.
//
// The table holds up to ENTRIES timing records, keys in one memory and statistics in a
// second, both with a registered read port. One beat is worked on at a time. A register
// beat walks the filled keys one per cycle through the key memory's read port until it
// finds a match or runs out of filled keys. Record and reset one beats read the addressed
// entry, modify it and write it back; a query beat only reads it. Reset all rewrites the
// statistics of every filled entry, one per cycle. A null key, an invalid index or an
// unused operation code goes straight to the result. A finished result sits in an output
// register, so the next beat is taken while it waits; a further result is held back
// until the waiting one has been taken. No clearing pass runs after reset: entries are
// written when registered.
module timing_statistics_table #(
	parameter int ENTRIES = tst_pkg::ENTRIES_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input beats.
	input  logic         s_tvalid,
	output logic         s_tready,
	// From bit 0: key[31:0], index[35:32], entry_time[67:36], exit_time[99:68], zero.
	input  logic [103:0] s_tdata,
	// operation[2:0].
	input  logic [2:0]   s_tuser,
	// Result beats.
	output logic         m_tvalid,
	input  logic         m_tready,
	// From bit 0: result_index[3:0], entry_key[35:4], calls[67:36], total_time[131:68],
	// min_time[163:132], max_time[195:164], last_time[227:196], filled_count[232:228], zero.
	output logic [239:0] m_tdata,
	// status[1:0].
	output logic [1:0]   m_tuser
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
	localparam int ST_W  = $bits(tst_pkg::stats_t);

	// Input fields.
	logic [31:0] in_key;
	logic [3:0]  in_index;
	logic [31:0] in_entry_time;
	logic [31:0] in_exit_time;
	logic        in_accept;
	logic        in_idx_ok;

	assign in_key        = s_tdata[31:0];
	assign in_index      = s_tdata[35:32];
	assign in_entry_time = s_tdata[67:36];
	assign in_exit_time  = s_tdata[99:68];

	// State and captured beat.
	tst_pkg::state_t state_q, state_d;
	tst_pkg::op_t    op_q;
	logic [31:0]     key_q;
	logic [3:0]      idx_q;
	logic [31:0]     delta_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] ptr_q;
	logic             cmp_vld_q;
	logic [IDX_W-1:0] cmp_idx_q;
	tst_pkg::rslt_t   res_q, res_d;
	tst_pkg::rslt_t   out_q;
	logic [4:0]       out_filled_q;
	logic             out_vld_q;

	// Memory ports.
	logic [IDX_W-1:0]     raddr;
	logic                 key_we;
	logic [IDX_W-1:0]     key_waddr;
	logic [31:0]          key_rdata;
	logic                 st_we;
	logic [IDX_W-1:0]     st_waddr;
	tst_pkg::stats_t      st_wdata;
	logic [ST_W-1:0]      st_rvec;
	tst_pkg::stats_t      st_rdata;
	tst_pkg::stats_t      upd;

	// Sequencer strobes.
	logic res_ld;
	logic out_ld;
	logic scan_issue;
	logic used_inc;
	logic ptr_adv;
	logic hit;
	logic more;

	assign st_rdata  = st_rvec;
	assign in_accept = s_tvalid && s_tready;
	assign in_idx_ok = CMP_W'(in_index) < CMP_W'(used_q);
	assign more      = ptr_q < used_q;
	assign hit       = cmp_vld_q && (key_rdata == key_q);

	tst_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_q),
		.raddr(raddr),
		.rdata(key_rdata)
	);

	tst_ram #(
		.WIDTH(ST_W),
		.DEPTH(ENTRIES)
	) u_stats_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(raddr),
		.rdata(st_rvec)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and result formation.
	always_comb begin
		state_d    = state_q;
		s_tready   = (state_q == tst_pkg::S_IDLE);
		raddr      = '0;
		key_we     = 1'b0;
		key_waddr  = used_q[IDX_W-1:0];
		st_we      = 1'b0;
		st_waddr   = used_q[IDX_W-1:0];
		st_wdata   = tst_pkg::cleared_stats();
		upd        = st_rdata;
		res_d      = '0;
		res_ld     = 1'b0;
		out_ld     = 1'b0;
		scan_issue = 1'b0;
		used_inc   = 1'b0;
		ptr_adv    = 1'b0;

		unique case (state_q)
			tst_pkg::S_IDLE: begin
				raddr = IDX_W'(in_index);
				if (in_accept) begin
					unique case (s_tuser) inside
						tst_pkg::OP_REGISTER: begin
							if (in_key == 32'd0) begin
								res_d.status = tst_pkg::ST_NULL_KEY;
								res_ld       = 1'b1;
								state_d      = tst_pkg::S_EMIT;
							end else begin
								state_d = tst_pkg::S_SCAN;
							end
						end
						tst_pkg::OP_RECORD, tst_pkg::OP_RESET_ONE, tst_pkg::OP_QUERY: begin
							if (in_idx_ok) begin
								state_d = tst_pkg::S_EXEC;
							end else begin
								res_d.status = tst_pkg::ST_BAD_INDEX;
								res_ld       = 1'b1;
								state_d      = tst_pkg::S_EMIT;
							end
						end
						tst_pkg::OP_RESET_ALL: begin
							state_d = tst_pkg::S_CLEAR;
						end
						default: begin
							res_ld  = 1'b1;
							state_d = tst_pkg::S_EMIT;
						end
					endcase
				end
			end

			// Keys are read one per cycle and each is compared in the cycle after its read.
			tst_pkg::S_SCAN: begin
				raddr      = ptr_q[IDX_W-1:0];
				scan_issue = more && !hit;
				if (hit) begin
					res_d.status       = tst_pkg::ST_OK;
					res_d.result_index = 4'(cmp_idx_q);
					res_d.entry_key    = key_rdata;
					res_d.stats        = st_rdata;
					res_ld             = 1'b1;
					state_d            = tst_pkg::S_EMIT;
				end else if (!cmp_vld_q && !more) begin
					if (used_q == CNT_W'(ENTRIES)) begin
						res_d.status = tst_pkg::ST_FULL;
					end else begin
						key_we             = 1'b1;
						st_we              = 1'b1;
						used_inc           = 1'b1;
						res_d.status       = tst_pkg::ST_OK;
						res_d.result_index = 4'(used_q);
						res_d.entry_key    = key_q;
						res_d.stats        = tst_pkg::cleared_stats();
					end
					res_ld  = 1'b1;
					state_d = tst_pkg::S_EMIT;
				end
			end

			// Read data of the addressed entry is here: modify and write back, except for a query.
			tst_pkg::S_EXEC: begin
				st_waddr = IDX_W'(idx_q);
				case (op_q)
					tst_pkg::OP_RECORD: begin
						upd.calls      = st_rdata.calls + 32'd1;
						upd.total_time = st_rdata.total_time + {32'd0, delta_q};
						upd.last_time  = delta_q;
						if (delta_q < st_rdata.min_time) begin
							upd.min_time = delta_q;
						end
						if (delta_q > st_rdata.max_time) begin
							upd.max_time = delta_q;
						end
					end
					tst_pkg::OP_RESET_ONE: begin
						upd = tst_pkg::cleared_stats();
					end
					default: begin
						upd = st_rdata;
					end
				endcase
				st_wdata        = upd;
				st_we           = (op_q != tst_pkg::OP_QUERY);
				res_d.status    = tst_pkg::ST_OK;
				res_d.entry_key = key_rdata;
				res_d.stats     = upd;
				res_ld          = 1'b1;
				state_d         = tst_pkg::S_EMIT;
			end

			// Sweep the filled entries, clearing their statistics.
			tst_pkg::S_CLEAR: begin
				st_waddr = ptr_q[IDX_W-1:0];
				if (more) begin
					st_we   = 1'b1;
					ptr_adv = 1'b1;
				end else begin
					res_ld  = 1'b1;
					state_d = tst_pkg::S_EMIT;
				end
			end

			// Hand the result over once the output register is free.
			tst_pkg::S_EMIT: begin
				if (!out_vld_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = tst_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = tst_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			ptr_q     <= '0;
			cmp_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_accept) begin
				ptr_q     <= '0;
				cmp_vld_q <= 1'b0;
			end else begin
				if (state_q == tst_pkg::S_SCAN) begin
					cmp_vld_q <= scan_issue;
				end
				if (scan_issue || ptr_adv) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
			end
			if (used_inc) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= tst_pkg::op_t'(s_tuser);
			key_q   <= in_key;
			idx_q   <= in_index;
			delta_q <= in_exit_time - in_entry_time;
		end
		if (state_q == tst_pkg::S_SCAN) begin
			cmp_idx_q <= ptr_q[IDX_W-1:0];
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			out_q        <= res_q;
			out_filled_q <= 5'(used_q);
		end
	end

	// Result beat.
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {7'd0, out_filled_q,
		out_q.stats.last_time, out_q.stats.max_time, out_q.stats.min_time,
		out_q.stats.total_time, out_q.stats.calls,
		out_q.entry_key, out_q.result_index};

endmodule

// ===== sim/tb_timing_statistics_table.sv =====
// Self-checking testbench for the timing statistics table, with a stream driver and monitor.
module tb_timing_statistics_table;
	timeunit 1ns;
	timeprecision 1ps;

	import tst_pkg::*;

	localparam int TABLE_SIZE   = tst_pkg::ENTRIES_DEFAULT;
	localparam int RANDOM_BEATS = 500;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int CALM_FROM    = 3000;
	localparam int CALM_TO      = 6000;

	// One request beat as the sender sees it.
	typedef struct {
		op_t         op;
		logic [31:0] key;
		logic [3:0]  index;
		logic [31:0] entry_time;
		logic [31:0] exit_time;
	} table_request_t;

	// One answer beat, unpacked into its fields.
	typedef struct packed {
		status_t     status;
		logic [3:0]  index;
		logic [31:0] key;
		logic [31:0] calls;
		logic [63:0] total_time;
		logic [31:0] min_time;
		logic [31:0] max_time;
		logic [31:0] last_time;
		logic [4:0]  filled;
	} table_answer_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata  = '0;
	logic [2:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [239:0] m_tdata;
	logic [1:0]   m_tuser;

	table_request_t pending_requests[$];
	table_answer_t  expected_answers[$];
	table_request_t current_request;
	logic [31:0]    key_pool[$];

	// Shadow copy of the table.
	logic [31:0] shadow_key[TABLE_SIZE];
	logic [31:0] shadow_calls[TABLE_SIZE];
	logic [63:0] shadow_total[TABLE_SIZE];
	logic [31:0] shadow_min[TABLE_SIZE];
	logic [31:0] shadow_max[TABLE_SIZE];
	logic [31:0] shadow_last[TABLE_SIZE];
	int          shadow_used = 0;

	int cycle_count = 0;
	int error_count = 0;
	int answer_count = 0;
	logic calm;

	timing_statistics_table #(
		.ENTRIES(TABLE_SIZE)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Free-running clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// A window of cycles in which neither side idles.
	assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

	// Cycle counter and run timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("Mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("answer %0d %s is %h, expected %h",
				answer_count, name, got, want));
	endtask

	// Statistics of a freshly registered or reset entry.
	function automatic void clear_shadow_entry(input int i);
		shadow_calls[i] = '0;
		shadow_total[i] = '0;
		shadow_min[i]   = '1;
		shadow_max[i]   = '0;
		shadow_last[i]  = '0;
	endfunction

	function automatic void show_entry(inout table_answer_t a, input int i);
		a.key        = shadow_key[i];
		a.calls      = shadow_calls[i];
		a.total_time = shadow_total[i];
		a.min_time   = shadow_min[i];
		a.max_time   = shadow_max[i];
		a.last_time  = shadow_last[i];
	endfunction

	// Applies one request to the shadow table and returns the answer it should produce.
	function automatic table_answer_t apply_to_table(input table_request_t r);
		table_answer_t a;
		int hit;
		int i;
		logic [31:0] elapsed;
		a = '0;
		a.status = ST_OK;
		hit = -1;
		case (r.op)
			OP_REGISTER: begin
				if (r.key == 32'd0) begin
					a.status = ST_NULL_KEY;
				end else begin
					for (i = 0; i < shadow_used; i++)
						if (hit < 0 && shadow_key[i] == r.key)
							hit = i;
					if (hit < 0) begin
						if (shadow_used >= TABLE_SIZE) begin
							a.status = ST_FULL;
						end else begin
							hit = shadow_used;
							shadow_key[hit] = r.key;
							clear_shadow_entry(hit);
							shadow_used++;
						end
					end
					if (hit >= 0) begin
						a.index = hit[3:0];
						show_entry(a, hit);
					end
				end
			end
			OP_RECORD, OP_RESET_ONE, OP_QUERY: begin
				if (int'(r.index) >= shadow_used) begin
					a.status = ST_BAD_INDEX;
				end else begin
					hit = int'(r.index);
					if (r.op == OP_RECORD) begin
						elapsed = r.exit_time - r.entry_time;
						shadow_calls[hit] = shadow_calls[hit] + 32'd1;
						shadow_total[hit] = shadow_total[hit] + {32'd0, elapsed};
						shadow_last[hit]  = elapsed;
						if (elapsed < shadow_min[hit])
							shadow_min[hit] = elapsed;
						if (elapsed > shadow_max[hit])
							shadow_max[hit] = elapsed;
					end else if (r.op == OP_RESET_ONE) begin
						clear_shadow_entry(hit);
					end
					show_entry(a, hit);
				end
			end
			OP_RESET_ALL: begin
				for (i = 0; i < shadow_used; i++)
					clear_shadow_entry(i);
			end
			default: begin
			end
		endcase
		a.filled = shadow_used[4:0];
		return a;
	endfunction

	task automatic queue_request(input op_t op, input logic [31:0] key, input logic [3:0] index,
			input logic [31:0] entry_time, input logic [31:0] exit_time);
		table_request_t r;
		r.op         = op;
		r.key        = key;
		r.index      = index;
		r.entry_time = entry_time;
		r.exit_time  = exit_time;
		pending_requests.push_back(r);
	endtask

	// Driver: predicts each accepted beat, then offers the next one unless it idles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_answers.push_back(apply_to_table(current_request));
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 &&
						(calm || $urandom_range(0, 99) >= 26)) begin
					current_request = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0000, current_request.exit_time,
						current_request.entry_time, current_request.index,
						current_request.key};
					s_tuser  <= current_request.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted answer against the oldest prediction.
	always @(posedge clk) begin
		table_answer_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch($sformatf("answer with no request outstanding, status %0d",
						m_tuser));
				end else begin
					want = expected_answers.pop_front();
					check_field("status", {62'd0, m_tuser}, {62'd0, want.status});
					check_field("result_index", {60'd0, m_tdata[3:0]}, {60'd0, want.index});
					check_field("entry_key", {32'd0, m_tdata[35:4]}, {32'd0, want.key});
					check_field("calls", {32'd0, m_tdata[67:36]}, {32'd0, want.calls});
					check_field("total_time", m_tdata[131:68], want.total_time);
					check_field("min_time", {32'd0, m_tdata[163:132]}, {32'd0, want.min_time});
					check_field("max_time", {32'd0, m_tdata[195:164]}, {32'd0, want.max_time});
					check_field("last_time", {32'd0, m_tdata[227:196]}, {32'd0, want.last_time});
					check_field("filled_count", {59'd0, m_tdata[232:228]}, {59'd0, want.filled});
				end
				answer_count <= answer_count + 1;
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 26);
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int n;
		int pick;
		op_t op;
		logic [31:0] key;
		logic [31:0] t_in;
		logic [31:0] t_out;

		// Directed beats: empty table, null key, wrap-around, bad indexes, resets.
		queue_request(OP_QUERY, 32'd0, 4'd0, 32'd0, 32'd0);
		queue_request(OP_REGISTER, 32'd0, 4'd0, 32'd0, 32'd0);
		queue_request(OP_REGISTER, 32'hFFFF_FFFF, 4'd0, 32'd0, 32'd0);
		queue_request(OP_REGISTER, 32'd1, 4'd0, 32'd0, 32'd0);
		queue_request(OP_REGISTER, 32'hFFFF_FFFF, 4'd0, 32'd0, 32'd0);
		queue_request(OP_RECORD, 32'd0, 4'd0, 32'd0, 32'hFFFF_FFFF);
		queue_request(OP_RECORD, 32'd0, 4'd0, 32'd5, 32'd5);
		queue_request(OP_RECORD, 32'd0, 4'd1, 32'hFFFF_FFFF, 32'd0);
		queue_request(OP_RECORD, 32'd0, 4'd1, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_request(OP_RECORD, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(OP_RESET_ONE, 32'd0, 4'd0, 32'd0, 32'd0);
		queue_request(OP_QUERY, 32'd0, 4'd1, 32'd0, 32'd0);
		queue_request(OP_QUERY, 32'd0, 4'd0, 32'd0, 32'd0);
		queue_request(OP_RESET_ALL, 32'd0, 4'd0, 32'd0, 32'd0);
		queue_request(OP_QUERY, 32'd0, 4'd1, 32'd0, 32'd0);
		queue_request(OP_RESET_ONE, 32'd0, 4'd2, 32'd0, 32'd0);
		queue_request(OP_REGISTER, 32'h8000_0000, 4'hF, 32'hFFFF_FFFF, 32'd0);
		key_pool.push_back(32'hFFFF_FFFF);
		key_pool.push_back(32'd1);
		key_pool.push_back(32'h8000_0000);

		// Random beats: records most often, at random indexes, registers that fill the table
		// and then hit it full, with resets and queries mixed in.
		for (n = 0; n < RANDOM_BEATS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				op = OP_REGISTER;
			else if (pick < 70)
				op = OP_RECORD;
			else if (pick < 78)
				op = OP_RESET_ONE;
			else if (pick < 83)
				op = OP_RESET_ALL;
			else
				op = OP_QUERY;
			pick = $urandom_range(0, 99);
			if (op == OP_REGISTER && pick < 3) begin
				key = 32'd0;
			end else if (op == OP_REGISTER && pick >= 40) begin
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end else begin
				key = $urandom;
				if (op == OP_REGISTER && key != 32'd0)
					key_pool.push_back(key);
			end
			t_in = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				t_out = t_in + $urandom_range(0, 5000);
			else if (pick < 85)
				t_out = $urandom;
			else
				t_out = t_in;
			queue_request(op, key, 4'($urandom_range(0, 15)), t_in, t_out);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to be taken and every answer to arrive, then drain.
		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
